FILE: src/slfd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// slfd_pkg - shared types and constants of the sync/length frame deframer
// Sync bytes, header length, result kind codes, phase encoding and the beat
// payload structures used on both stream channels.
// ============================================================================
package slfd_pkg;

   // Sync word, in arrival order
   localparam logic [7:0] SYNC_A = 8'hE2;
   localparam logic [7:0] SYNC_B = 8'h98;
   localparam logic [7:0] SYNC_C = 8'hA2;

   localparam int unsigned SIZE_BYTES = 4;
   localparam int unsigned STAMP_BYTES = 8;
   localparam int unsigned HDR_BYTES = 16;

   localparam logic [31:0] SIZE_BYTES_W = 32'(SIZE_BYTES);
   localparam logic [31:0] STAMP_BYTES_W = 32'(STAMP_BYTES);
   localparam logic [31:0] HDR_BYTES_W = 32'(HDR_BYTES);

   // Result kind codes
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_SIZE_ERR = 2'd2;

   typedef enum logic [5:0] {
      PH_HUNT0 = 6'b000001,
      PH_HUNT1 = 6'b000010,
      PH_HUNT2 = 6'b000100,
      PH_SIZE  = 6'b001000,
      PH_HEAD  = 6'b010000,
      PH_DATA  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [31:0] frame_size;
      logic [63:0] stamp;
      logic [63:0] type_hash;
      logic        last;
   } rsp_payload_type;

   // Result of one step of the deframer core
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } step_result_type;

endpackage

FILE: src/slfd_stream_if.sv
`timescale 1ns / 1ps
// ============================================================================
// slfd_stream_if - valid/ready stream channel
// Carries one beat of a packed payload type per handshake.
// ============================================================================
interface slfd_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/sync_length_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// sync_length_frame_deframer_unit - streaming sync/length frame deframer
// Hunts for the E2 98 A2 sync word, then streams frame payload bytes out with
// the frame's size, timestamp and type hash attached.
// ============================================================================
// The block takes one received byte per beat on req_bus and accepts a new
// byte every clock cycle while rsp_bus is not stalled. Each byte passes an
// input register, one pass of the deframer step logic, and the result
// register, from which its result is offered on rsp_bus. The sustained rate
// of one byte per cycle is set by the state update of the step logic.
// Only payload bytes after the 16-byte timestamp/hash header produce beats
// (kind 0, last on the final one); a size of exactly 16 gives one empty-frame
// beat (kind 1) and a size below 16 gives one size-error beat (kind 2) with
// zero stamp and hash. Both end the frame and restart the sync hunt. A byte
// that breaks the sync word is not retried as a sync start. Backpressure on
// rsp_bus stalls the step logic; the input register still holds one byte.
module sync_length_frame_deframer_unit
   import slfd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   slfd_stream_if.sink   req_bus,
   slfd_stream_if.source rsp_bus
);

   // Input register
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;

   // Result register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;

   logic            out_free;
   logic            step_en;
   logic            req_fire;
   step_result_type step_result;

   // The result register can take a new beat when empty or being drained
   assign out_free = !out_valid_ff || rsp_bus.ready;
   // Advance the held byte through the step logic when its result has room
   assign step_en = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign req_fire = req_bus.valid && req_bus.ready;

   slfd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .rx_byte (in_byte_ff),
      .result  (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in = req_bus.payload.rx_byte;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      if (step_en) begin
         // load the step result; a byte with no result empties the register
         out_valid_in = step_result.valid;
         out_data_in = step_result.payload;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.payload = out_data_ff;

`ifndef SYNTHESIS
   // A byte blocked by a stalled result register stays held and unchanged
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held input byte lost or changed during stall");

   // Empty-frame and size-error beats always close the frame
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_data_ff.kind != KIND_DATA) |-> out_data_ff.last)
      else $error("non-data beat without last");

   // A size-error beat carries a short size and no header fields
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_data_ff.kind == KIND_SIZE_ERR) |->
         (out_data_ff.frame_size < HDR_BYTES_W) && (out_data_ff.stamp == '0) &&
         (out_data_ff.type_hash == '0) && (out_data_ff.data_byte == '0))
      else $error("malformed size-error beat");

   // Only known kind codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.kind == KIND_DATA) ||
         (out_data_ff.kind == KIND_EMPTY) || (out_data_ff.kind == KIND_SIZE_ERR))
      else $error("unknown result kind");
`endif

endmodule

FILE: src/slfd_core.sv
`timescale 1ns / 1ps
// ============================================================================
// slfd_core - deframer state and single-pass step logic
// Holds phase, byte count and header fields; computes the result of one byte.
// ============================================================================
module slfd_core
   import slfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic [7:0]      rx_byte,
   output step_result_type result
);

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] size_ff, size_in;
   logic [63:0] stamp_ff, stamp_in;
   logic [63:0] hash_ff, hash_in;

   logic [31:0] count_inc;
   logic [31:0] size_shift;

   assign count_inc = count_ff + 32'd1;
   assign size_shift = {rx_byte, size_ff[31:8]};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      size_in = size_ff;
      stamp_in = stamp_ff;
      hash_in = hash_ff;
      result = '0;
      unique case (phase_ff)
         PH_HUNT1: begin
            phase_in = (rx_byte == SYNC_B) ? PH_HUNT2 : PH_HUNT0;
         end
         PH_HUNT2: begin
            if (rx_byte == SYNC_C) begin
               phase_in = PH_SIZE;
               count_in = '0;
            end else begin
               phase_in = PH_HUNT0;
            end
         end
         PH_SIZE: begin
            size_in = size_shift;
            count_in = count_inc;
            if (count_inc >= SIZE_BYTES_W) begin
               count_in = '0;
               if (size_shift < HDR_BYTES_W) begin
                  // drop the frame, report the bad size
                  phase_in = PH_HUNT0;
                  result.valid = 1'b1;
                  result.payload.kind = KIND_SIZE_ERR;
                  result.payload.frame_size = size_shift;
                  result.payload.last = 1'b1;
               end else begin
                  phase_in = PH_HEAD;
               end
            end
         end
         PH_HEAD: begin
            if (count_ff < STAMP_BYTES_W) begin
               stamp_in = {rx_byte, stamp_ff[63:8]};
            end else begin
               hash_in = {rx_byte, hash_ff[63:8]};
            end
            count_in = count_inc;
            if (count_inc >= HDR_BYTES_W) begin
               count_in = '0;
               if (size_ff == HDR_BYTES_W) begin
                  phase_in = PH_HUNT0;
                  result.valid = 1'b1;
                  result.payload.kind = KIND_EMPTY;
                  result.payload.frame_size = size_ff;
                  result.payload.stamp = stamp_in;
                  result.payload.type_hash = hash_in;
                  result.payload.last = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            count_in = count_inc;
            result.valid = 1'b1;
            result.payload.kind = KIND_DATA;
            result.payload.data_byte = rx_byte;
            result.payload.frame_size = size_ff;
            result.payload.stamp = stamp_ff;
            result.payload.type_hash = hash_ff;
            result.payload.last = (count_inc >= (size_ff - HDR_BYTES_W));
            if (result.payload.last) begin
               phase_in = PH_HUNT0;
               count_in = '0;
            end
         end
         default: begin
            phase_in = (rx_byte == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT0;
         count_ff <= '0;
         size_ff <= '0;
         stamp_ff <= '0;
         hash_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         size_ff <= size_in;
         stamp_ff <= stamp_in;
         hash_ff <= hash_in;
      end
   end

endmodule

FILE: tb/tb_sync_length_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_sync_length_frame_deframer_unit - self-checking bench of the deframer
// Offers byte streams built from sync words, broken sync words, size-error,
// empty and data frames, plus random noise. A byte-level shadow deframer
// predicts every result beat, and each accepted beat is checked field by
// field. Both stream sides idle at random, and one long receiver hold-off
// backs the block up until it stalls its input.
// ============================================================================
module tb_sync_length_frame_deframer_unit;
   import slfd_pkg::*;

   localparam int CYCLE_LIMIT = 500000;   // generous ceiling for the whole run
   localparam int DRAIN_CYCLES = 8;       // extra wait after the last expected beat
   localparam int RANDOM_BYTES = 580;     // framed bytes per idling phase
   localparam int HOLD_OFF_CYCLES = 400;  // long receiver stall

   logic clock;
   logic reset;

   slfd_stream_if #(.payload_type(req_payload_type)) req_bus ();
   slfd_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   sync_length_frame_deframer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Idle odds in percent, changed by the tests between phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Hold-off request from a test; the receiver process owns the countdown
   int hold_request = 0;
   int hold_left = 0;

   // Shadow deframer state
   phase_type   pred_phase;
   logic [31:0] pred_count;
   logic [31:0] pred_size;
   logic [63:0] pred_stamp;
   logic [63:0] pred_hash;

   rsp_payload_type expected_beats[$];
   rsp_payload_type want_beat;

   int mismatches = 0;
   int cycle_count = 0;
   int bytes_offered = 0;
   int frames_sent = 0;
   int beats_checked = 0;
   int data_beats = 0;
   int empty_beats = 0;
   int error_beats = 0;

   // -------------------------------------------------------------------------
   // Clock and watchdog
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Shadow deframer: advance one byte, queue the beat it causes, if any
   // -------------------------------------------------------------------------
   function automatic void deframe_byte(input logic [7:0] b);
      rsp_payload_type beat;
      bit fire;
      beat = '0;
      fire = 1'b0;
      case (pred_phase)
         PH_HUNT1: begin
            pred_phase = (b == SYNC_B) ? PH_HUNT2 : PH_HUNT0;
         end
         PH_HUNT2: begin
            if (b == SYNC_C) begin
               pred_phase = PH_SIZE;
               pred_count = '0;
            end else begin
               pred_phase = PH_HUNT0;
            end
         end
         PH_SIZE: begin
            pred_size = {b, pred_size[31:8]};
            pred_count++;
            if (pred_count >= SIZE_BYTES_W) begin
               pred_count = '0;
               if (pred_size < HDR_BYTES_W) begin
                  // Size too small: flag it, zero stamp and hash, restart hunt
                  pred_phase = PH_HUNT0;
                  fire = 1'b1;
                  beat.kind = KIND_SIZE_ERR;
                  beat.frame_size = pred_size;
                  beat.last = 1'b1;
               end else begin
                  pred_phase = PH_HEAD;
               end
            end
         end
         PH_HEAD: begin
            if (pred_count < STAMP_BYTES_W)
               pred_stamp = {b, pred_stamp[63:8]};
            else
               pred_hash = {b, pred_hash[63:8]};
            pred_count++;
            if (pred_count >= HDR_BYTES_W) begin
               pred_count = '0;
               if (pred_size == HDR_BYTES_W) begin
                  // Header only: one empty-frame beat ends the frame
                  pred_phase = PH_HUNT0;
                  fire = 1'b1;
                  beat.kind = KIND_EMPTY;
                  beat.frame_size = pred_size;
                  beat.stamp = pred_stamp;
                  beat.type_hash = pred_hash;
                  beat.last = 1'b1;
               end else begin
                  pred_phase = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            pred_count++;
            beat.last = (pred_count >= pred_size - HDR_BYTES_W);
            if (beat.last) begin
               pred_phase = PH_HUNT0;
               pred_count = '0;
            end
            fire = 1'b1;
            beat.kind = KIND_DATA;
            beat.data_byte = b;
            beat.frame_size = pred_size;
            beat.stamp = pred_stamp;
            beat.type_hash = pred_hash;
         end
         default: begin
            pred_phase = (b == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
         end
      endcase
      if (fire)
         expected_beats = {expected_beats, beat};
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Receiver: check each accepted beat against the oldest expectation, then
   // drive ready for the next edge (random idling or a requested hold-off)
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end

      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            $error("result beat with no expectation: kind %0d data 0x%0h",
                   rsp_bus.payload.kind, rsp_bus.payload.data_byte);
            mismatches++;
         end else begin
            want_beat = expected_beats.pop_front();
            check_field("kind", 64'(want_beat.kind), 64'(rsp_bus.payload.kind));
            check_field("data_byte", 64'(want_beat.data_byte),
                        64'(rsp_bus.payload.data_byte));
            check_field("frame_size", 64'(want_beat.frame_size),
                        64'(rsp_bus.payload.frame_size));
            check_field("stamp", want_beat.stamp, rsp_bus.payload.stamp);
            check_field("type_hash", want_beat.type_hash, rsp_bus.payload.type_hash);
            check_field("last", 64'(want_beat.last), 64'(rsp_bus.payload.last));
            beats_checked++;
            case (want_beat.kind)
               KIND_DATA:     data_beats++;
               KIND_EMPTY:    empty_beats++;
               KIND_SIZE_ERR: error_beats++;
               default: ;
            endcase
         end
      end

      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Sender helpers; every task is entered and left right after a rising edge
   // -------------------------------------------------------------------------

   // Offer one byte, idling first at random; predict once the beat is taken
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload.rx_byte <= value;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      bytes_offered++;
      deframe_byte(value);
   endtask

   // Sync word, size, then stamp and hash when the size admits a header
   task automatic send_header(input logic [31:0] size, input logic [63:0] stamp,
                              input logic [63:0] hash);
      send_byte(SYNC_A);
      send_byte(SYNC_B);
      send_byte(SYNC_C);
      for (int i = 0; i < 4; i++)
         send_byte(size[8*i +: 8]);
      if (size >= HDR_BYTES_W) begin
         for (int i = 0; i < 8; i++)
            send_byte(stamp[8*i +: 8]);
         for (int i = 0; i < 8; i++)
            send_byte(hash[8*i +: 8]);
      end
      frames_sent++;
   endtask

   // Whole frame with random header and payload
   task automatic send_frame(input logic [31:0] size);
      send_header(size, {$urandom, $urandom}, {$urandom, $urandom});
      if (size > HDR_BYTES_W) begin
         for (int i = 0; i < int'(size - HDR_BYTES_W); i++)
            send_byte(8'($urandom));
      end
   endtask

   // Drop valid and wait until every expected beat has come out
   task automatic drain;
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // A byte that breaks the sync word must not start a new one, so none of
   // these sequences may produce the size-error beat their tails would cause
   task automatic test_broken_sync;
      logic [7:0] seq_a[8] = '{8'hE2, 8'hE2, 8'h98, 8'hA2, 8'h05, 8'h00, 8'h00, 8'h00};
      logic [7:0] seq_b[9] = '{8'hE2, 8'h98, 8'hE2, 8'h98, 8'hA2, 8'h05, 8'h00, 8'h00,
                               8'h00};
      foreach (seq_a[i]) send_byte(seq_a[i]);
      foreach (seq_b[i]) send_byte(seq_b[i]);
      drain();
   endtask

   // Sizes below the header length: zero and fifteen
   task automatic test_size_error;
      send_header(32'd0, '0, '0);
      send_header(32'd15, '0, '0);
      drain();
   endtask

   // Size exactly the header length gives one empty-frame beat
   task automatic test_empty_frame;
      send_header(HDR_BYTES_W, 64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF);
      drain();
   endtask

   // Extreme and sync-like payload bytes, then a single-byte frame
   task automatic test_data_frame;
      send_header(HDR_BYTES_W + 32'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_A);
      send_byte(SYNC_B);
      send_frame(HDR_BYTES_W + 32'd1);
      drain();
   endtask

   // Hold the receiver off while the sender keeps offering a long frame
   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = HOLD_OFF_CYCLES;
      send_frame(HDR_BYTES_W + 32'd60);
      drain();
   endtask

   // Mostly well-formed frames with random content, some broken sync words
   // and some noise; the noise does not count toward the byte budget
   task automatic test_random_frames(input int send_pct, input int recv_pct);
      int framed;
      int mark;
      int pick;
      int sel;
      logic [7:0] bad;
      framed = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (framed < RANDOM_BYTES) begin
         pick = $urandom_range(99);
         mark = bytes_offered;
         if (pick < 8) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
         end else begin
            if (pick < 16) begin
               send_byte(SYNC_A);
               if ($urandom_range(1)) begin
                  send_byte(SYNC_B);
                  do bad = 8'($urandom); while (bad == SYNC_C);
               end else begin
                  do bad = 8'($urandom); while (bad == SYNC_B);
               end
               send_byte(bad);
            end else begin
               sel = $urandom_range(99);
               if (sel < 12)
                  send_frame(32'($urandom_range(15, 0)));
               else if (sel < 24)
                  send_frame(HDR_BYTES_W);
               else if (sel < 95)
                  send_frame(32'($urandom_range(56, 17)));
               else
                  send_frame(32'($urandom_range(700, 57)));
            end
            framed += bytes_offered - mark;
         end
      end
      drain();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;

      pred_phase = PH_HUNT0;
      pred_count = '0;
      pred_size = '0;
      pred_stamp = '0;
      pred_hash = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      recv_idle_pct = 30;
      test_broken_sync();
      test_size_error();
      test_empty_frame();
      test_data_frame();
      test_backpressure();
      test_random_frames(21, 78);
      test_random_frames(78, 21);
      test_random_frames(0, 0);

      $display("Offered %0d bytes in %0d frames plus broken sync words and noise",
               bytes_offered, frames_sent);
      $display("Checked %0d beats: %0d payload, %0d empty frame, %0d size error",
               beats_checked, data_beats, empty_beats, error_beats);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
